// ----- src/spq_pkg.sv -----
// shared codes and types for the sorted priority queue
package spq_pkg;

  localparam int unsigned OP_BITS     = 2;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned COUNT_BITS  = 7;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_UPDATE = 2'd2,
    OP_PEEK   = 2'd3
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_INSERT = 2'd3
  } cell_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_REMOVE = 4'b0010,
    S_APPLY  = 4'b0100,
    S_REPORT = 4'b1000
  } state_t;

endpackage

// ----- src/spq_cell.sv -----
// one slot of the sorted chain: holds an entry and shifts to or from its neighbours
module spq_cell import spq_pkg::*; #(
  parameter int unsigned COORD_BITS = 8,
  parameter int unsigned PRIO_BITS  = 16,
  parameter int unsigned EW         = 1 + 2 * COORD_BITS + PRIO_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_cmd_t             cmd,
  input  logic [EW-1:0]         prev_ent,
  input  logic [EW-1:0]         next_ent,
  input  logic                  prev_ahead,
  input  logic                  prev_seen,
  input  logic [COORD_BITS-1:0] new_row,
  input  logic [COORD_BITS-1:0] new_col,
  input  logic [PRIO_BITS-1:0]  new_prio,
  output logic [EW-1:0]         ent,
  output logic                  ahead,
  output logic                  seen
);

  logic                  vld_r;
  logic                  vld_nxt;
  logic [EW-2:0]         dat_r;
  logic [EW-2:0]         dat_nxt;
  logic [COORD_BITS-1:0] cur_row;
  logic [COORD_BITS-1:0] cur_col;
  logic [PRIO_BITS-1:0]  cur_prio;
  logic                  match;

  assign cur_row  = dat_r[EW-2 -: COORD_BITS];
  assign cur_col  = dat_r[PRIO_BITS +: COORD_BITS];
  assign cur_prio = dat_r[PRIO_BITS-1:0];
  assign ent      = {vld_r, dat_r};

  // first matching slot and everything behind it close up on removal
  assign match  = vld_r && (cur_row == new_row) && (cur_col == new_col);
  assign seen   = prev_seen || match;
  // new entry goes in front of this slot
  assign ahead  = !vld_r || (cur_prio < new_prio);

  always_comb begin
    vld_nxt = vld_r;
    dat_nxt = dat_r;
    case (cmd)
      CMD_POP: begin
        {vld_nxt, dat_nxt} = next_ent;
      end
      CMD_REMOVE: begin
        if (seen) begin
          {vld_nxt, dat_nxt} = next_ent;
        end
      end
      CMD_INSERT: begin
        if (prev_ahead) begin
          {vld_nxt, dat_nxt} = prev_ent;
        end else if (ahead) begin
          vld_nxt = 1'b1;
          dat_nxt = {new_row, new_col, new_prio};
        end
      end
      default: begin
        vld_nxt = vld_r;
        dat_nxt = dat_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dat_r <= dat_nxt;
  end

endmodule

// ----- src/sorted_priority_queue.sv -----
// sorted priority queue built as a chain of slot cells with a small sequencer
// insert, pop and peek pass through the apply and report steps before their result is registered;
// update first passes through a remove step; a new item is accepted in the report step when the
// output is free, so a new item is not taken while the cell chain is busy with the last one
// reset: synchronous active-low rst_n empties every slot and clears the count
// one more item is accepted behind a waiting result; its report step then stalls the input
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned COORD_BITS = 8,
  parameter int unsigned PRIO_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_BITS-1:0]     in_op,
  input  logic [COORD_BITS-1:0]  in_row,
  input  logic [COORD_BITS-1:0]  in_col,
  input  logic [PRIO_BITS-1:0]   in_priority_req,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_BITS-1:0] out_status,
  output logic [COORD_BITS-1:0]  out_head_row,
  output logic [COORD_BITS-1:0]  out_head_col,
  output logic [COUNT_BITS-1:0]  out_count
);

  localparam int unsigned EW = 1 + 2 * COORD_BITS + PRIO_BITS;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_t                 state_r;
  state_t                 state_nxt;
  op_t                    op_r;
  logic [COORD_BITS-1:0]  row_r;
  logic [COORD_BITS-1:0]  col_r;
  logic [PRIO_BITS-1:0]   prio_r;
  logic [CW-1:0]          occ_r;
  logic [CW-1:0]          occ_nxt;
  status_t                status_r;
  logic [COORD_BITS-1:0]  pop_row_r;
  logic [COORD_BITS-1:0]  pop_col_r;
  logic                   out_valid_r;
  logic [STATUS_BITS-1:0] out_status_r;
  logic [COORD_BITS-1:0]  out_row_r;
  logic [COORD_BITS-1:0]  out_col_r;
  logic [COUNT_BITS-1:0]  out_count_r;

  logic                   accept;
  logic                   out_free;
  logic                   full;
  logic                   empty;
  cell_cmd_t              cmd;
  logic [EW-1:0]          ent    [CAPACITY];
  logic                   ahead  [CAPACITY];
  logic                   seen   [CAPACITY];
  logic                   head_vld;
  logic [COORD_BITS-1:0]  head_row;
  logic [COORD_BITS-1:0]  head_col;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_REPORT) && out_free);
  assign accept   = in_valid && in_ready;
  assign full     = (occ_r == CW'(CAPACITY));
  assign empty    = (occ_r == '0);

  assign head_vld = ent[0][EW-1];
  assign head_row = head_vld ? ent[0][EW-2 -: COORD_BITS] : '0;
  assign head_col = head_vld ? ent[0][PRIO_BITS +: COORD_BITS] : '0;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [EW-1:0] prev_ent;
    logic [EW-1:0] next_ent;
    logic          prev_ahead;
    logic          prev_seen;
    if (i == 0) begin : g_first
      assign prev_ent    = '0;
      assign prev_ahead  = 1'b0;
      assign prev_seen   = 1'b0;
    end else begin : g_mid
      assign prev_ent    = ent[i-1];
      assign prev_ahead  = ahead[i-1];
      assign prev_seen   = seen[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_body
      assign next_ent = ent[i+1];
    end
    spq_cell #(
      .COORD_BITS (COORD_BITS),
      .PRIO_BITS  (PRIO_BITS),
      .EW         (EW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .prev_ent    (prev_ent),
      .next_ent    (next_ent),
      .prev_ahead  (prev_ahead),
      .prev_seen   (prev_seen),
      .new_row     (row_r),
      .new_col     (col_r),
      .new_prio    (prio_r),
      .ent         (ent[i]),
      .ahead       (ahead[i]),
      .seen        (seen[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_HOLD;
    occ_nxt   = occ_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (op_t'(in_op) == OP_UPDATE) ? S_REMOVE : S_APPLY;
        end
      end
      S_REMOVE: begin
        cmd       = CMD_REMOVE;
        state_nxt = S_APPLY;
        if (seen[CAPACITY-1]) begin
          occ_nxt = occ_r - CW'(1);
        end
      end
      S_APPLY: begin
        state_nxt = S_REPORT;
        case (op_r)
          OP_INSERT, OP_UPDATE: begin
            if (!full) begin
              cmd     = CMD_INSERT;
              occ_nxt = occ_r + CW'(1);
            end
          end
          OP_POP: begin
            if (!empty) begin
              cmd     = CMD_POP;
              occ_nxt = occ_r - CW'(1);
            end
          end
          default: begin
            cmd = CMD_HOLD;
          end
        endcase
      end
      S_REPORT: begin
        if (out_free) begin
          if (accept) begin
            state_nxt = (op_t'(in_op) == OP_UPDATE) ? S_REMOVE : S_APPLY;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if ((state_r == S_REPORT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_op);
      row_r  <= in_row;
      col_r  <= in_col;
      prio_r <= in_priority_req;
    end
    if (state_r == S_APPLY) begin
      pop_row_r <= head_row;
      pop_col_r <= head_col;
      status_r  <= ST_OK;
      case (op_r)
        OP_INSERT, OP_UPDATE: begin
          if (full) begin
            status_r <= ST_FULL;
          end
        end
        OP_POP, OP_PEEK: begin
          if (empty) begin
            status_r <= ST_EMPTY;
          end
        end
        default: begin
          status_r <= ST_OK;
        end
      endcase
    end
    if ((state_r == S_REPORT) && out_free) begin
      out_status_r <= status_r;
      out_count_r  <= COUNT_BITS'(occ_r);
      if (op_r == OP_POP) begin
        out_row_r <= pop_row_r;
        out_col_r <= pop_col_r;
      end else begin
        out_row_r <= head_row;
        out_col_r <= head_col;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_head_row = out_row_r;
  assign out_head_col = out_col_r;
  assign out_count    = out_count_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    head_vld == !empty)
    else $error("head slot validity disagrees with occupancy");

  a_tail_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ent[CAPACITY-1][EW-1] == full)
    else $error("last slot validity disagrees with occupancy");

endmodule
